@@ src/key_matrix_debounce_scanner_unit_assert.svh @@
// Assertion helpers for the key matrix scanner.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_ASSERT_SVH
`define KEY_MATRIX_DEBOUNCE_SCANNER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KMDS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("key matrix scanner: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define KMDS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("key matrix scanner: next-cycle check failed");

`endif

@@ src/kmds_pkg.sv @@
`default_nettype none
package kmds_pkg;

  localparam int ROWS       = 8;
  localparam int COLS       = 16;
  localparam int TIME_W     = 32;
  localparam int ROW_W      = 3;
  localparam int COL_W      = 4;
  localparam int LVL_W      = 16;
  localparam int ROW_IDX_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W      = 8;
  localparam int DEB_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int OUT_TIME_W = 32;

  localparam logic [DEB_W-1:0] DEBOUNCE_RESET = DEB_W'(5);
  localparam logic [CNT_W-1:0] MAX_EV_RESET   = CNT_W'(128);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_MS = 2'd0,
    REG_MAX_EVENTS  = 2'd1
  } cfg_reg_t;

  // Result of one column lane for the row item just taken.
  typedef struct packed {
    logic fire;
    logic level;
  } lane_res_t;

  // One row item after the lanes, waiting for the event emitter.
  typedef struct packed {
    logic [COLS-1:0]   fire;
    logic [COLS-1:0]   level;
    logic [ROW_W-1:0]  row;
    logic [TIME_W-1:0] stamp;
  } row_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  key_row;
    logic [COL_W-1:0]  key_column;
    logic              is_pressed;
    logic [TIME_W-1:0] time_ms;
    logic              last;
  } event_t;

endpackage
`default_nettype wire

@@ src/kmds_lane.sv @@
`default_nettype none
module kmds_lane (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           take,
  input  logic [kmds_pkg::ROW_IDX_W-1:0] row,
  input  logic                           pressed,
  input  logic [kmds_pkg::TIME_W-1:0]    now,
  input  logic [kmds_pkg::DEB_W-1:0]     debounce,
  output kmds_pkg::lane_res_t            res
);
  import kmds_pkg::*;

  logic [ROWS-1:0]   raw_r,   raw_nxt;
  logic [ROWS-1:0]   stable_r, stable_nxt;
  logic [TIME_W-1:0] stamp_r [ROWS];

  logic              raw_chg;
  logic [TIME_W-1:0] elapsed;
  logic              fire;

  // A raw change restarts the timer, so the elapsed time is then zero.
  assign raw_chg = (pressed != raw_r[row]);
  assign elapsed = raw_chg ? '0 : (now - stamp_r[row]);
  assign fire    = (elapsed >= TIME_W'(debounce)) && (stable_r[row] != pressed);

  assign res.fire  = fire;
  assign res.level = pressed;

  always_comb begin
    raw_nxt    = raw_r;
    stable_nxt = stable_r;
    if (take) begin
      raw_nxt[row] = pressed;
      if (fire) begin
        stable_nxt[row] = pressed;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= '0;
      stable_r <= '0;
      for (int r = 0; r < ROWS; r++) begin
        stamp_r[r] <= '0;
      end
    end else begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      if (take && raw_chg) begin
        stamp_r[row] <= now;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/kmds_merge.sv @@
`default_nettype none
module kmds_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       s1_valid,
  input  kmds_pkg::row_item_t        s1_item,
  input  logic [kmds_pkg::CNT_W-1:0] max_events,
  output logic                       s1_take,
  output logic                       out_valid,
  input  logic                       out_ready,
  output kmds_pkg::event_t           ev
);
  import kmds_pkg::*;

  logic              em_valid_r, em_valid_nxt;
  logic [COLS-1:0]   em_mask_r,  em_mask_nxt;
  logic [COLS-1:0]   em_level_r, em_level_nxt;
  logic [ROW_W-1:0]  em_row_r,   em_row_nxt;
  logic [TIME_W-1:0] em_time_r,  em_time_nxt;
  logic [CNT_W-1:0]  cnt_r,      cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  event_t            ev_r,        ev_nxt;

  logic              cap_ok, out_free, step, emit, last, done, em_free;
  logic [COLS-1:0]   onehot, rest;
  logic [CNT_W-1:0]  cnt_inc;
  logic [COL_W-1:0]  col;

  assign cap_ok   = (cnt_r < max_events);
  assign out_free = !out_valid_r || out_ready;
  // Once the cap is reached the rest of the row is dropped without output.
  assign step     = em_valid_r && (!cap_ok || out_free);
  assign emit     = step && cap_ok;
  assign onehot   = em_mask_r & (~em_mask_r + COLS'(1));
  assign rest     = em_mask_r & ~onehot;
  assign cnt_inc  = cnt_r + CNT_W'(1);
  assign last     = (rest == '0) || (cnt_inc == max_events);
  assign done     = !cap_ok || last;
  assign em_free  = !em_valid_r || (step && done);
  assign s1_take  = em_free && s1_valid;

  always_comb begin
    col = '0;
    for (int c = 0; c < COLS; c++) begin
      if (onehot[c]) begin
        col = col | COL_W'(c);
      end
    end
  end

  always_comb begin
    em_valid_nxt  = em_valid_r;
    em_mask_nxt   = em_mask_r;
    em_level_nxt  = em_level_r;
    em_row_nxt    = em_row_r;
    em_time_nxt   = em_time_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    ev_nxt        = ev_r;

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt     = 1'b1;
      ev_nxt.key_row    = em_row_r;
      ev_nxt.key_column = col;
      ev_nxt.is_pressed = |(onehot & em_level_r);
      ev_nxt.time_ms    = em_time_r;
      ev_nxt.last       = last;
      em_mask_nxt       = rest;
      cnt_nxt           = cnt_inc;
    end
    if (step && done) begin
      em_valid_nxt = 1'b0;
    end
    if (s1_take) begin
      em_valid_nxt = |s1_item.fire;
      em_mask_nxt  = s1_item.fire;
      em_level_nxt = s1_item.level;
      em_row_nxt   = s1_item.row;
      em_time_nxt  = s1_item.stamp;
      if (s1_item.row == '0) begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r  <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      em_valid_r  <= em_valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    em_mask_r  <= em_mask_nxt;
    em_level_r <= em_level_nxt;
    em_row_r   <= em_row_nxt;
    em_time_r  <= em_time_nxt;
    ev_r       <= ev_nxt;
  end

  assign out_valid = out_valid_r;
  assign ev        = ev_r;

endmodule
`default_nettype wire

@@ src/key_matrix_debounce_scanner_unit.sv @@
`default_nettype none
// Keyboard matrix scanner with per-key debounce. Each input item is one sampled
// row (row index, active-low column levels, millisecond time stamp); each result
// item is one press or release event of a key in that row, in column order, with
// last_of_row set on the final event the row produced. When a row item is taken,
// sixteen column lanes update their keys' raw level, debounced level and
// change time stamp in parallel and flag the keys whose debounced level flips.
// The row item then waits in the row stage. The flagged keys leave one per
// cycle through the event emitter while the sink keeps up; a row with none
// passes the emitter without holding it. A second row item is buffered while
// the emitter drains, so rows with at most one event each flow at one per
// cycle while the sink keeps up. The row stage, the emitter and the output
// register lie between a taken row item and its first event. Row 0 opens a
// new scan and clears the per-scan event count; once max_events events went
// out in a scan, further flips still update the keys but produce no result
// item. Configuration writes are always ready and must only be made while
// the block is idle.
module key_matrix_debounce_scanner_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kmds_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kmds_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [kmds_pkg::ROW_W-1:0]          in_row_index,
  input  logic [kmds_pkg::LVL_W-1:0]          in_column_levels,
  input  logic [31:0]                         in_now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [kmds_pkg::ROW_W-1:0]          out_key_row,
  output logic [kmds_pkg::COL_W-1:0]          out_key_column,
  output logic                                out_is_pressed,
  output logic [kmds_pkg::OUT_TIME_W-1:0]     out_event_time_ms,
  output logic                                out_last_of_row
);
  import kmds_pkg::*;

  `include "key_matrix_debounce_scanner_unit_assert.svh"

  // Configuration registers.
  logic [DEB_W-1:0] debounce_r, debounce_nxt;
  logic [CNT_W-1:0] max_ev_r,   max_ev_nxt;

  // Row stage between the lanes and the emitter.
  logic      s1_valid_r, s1_valid_nxt;
  row_item_t s1_item_r,  s1_item_nxt;

  logic              in_acc, row_ok, lane_take, s1_take;
  logic [TIME_W-1:0] now;
  lane_res_t         lane_res [COLS];
  event_t            ev;

  assign cfg_ready = 1'b1;

  always_comb begin
    debounce_nxt = debounce_r;
    max_ev_nxt   = max_ev_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DEBOUNCE_MS: debounce_nxt = cfg_data[DEB_W-1:0];
        REG_MAX_EVENTS:  max_ev_nxt   = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // The row stage can take a new item whenever it is empty or the emitter
  // is pulling its current item in the same cycle.
  assign in_ready  = !s1_valid_r || s1_take;
  assign in_acc    = in_valid && in_ready;
  assign row_ok    = (32'(in_row_index) < ROWS);
  assign lane_take = in_acc && row_ok;
  assign now       = in_now_ms[TIME_W-1:0];

  for (genvar c = 0; c < COLS; c++) begin : g_lane
    kmds_lane u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .take     (lane_take),
      .row      (in_row_index[ROW_IDX_W-1:0]),
      .pressed  (!in_column_levels[c]),
      .now      (now),
      .debounce (debounce_r),
      .res      (lane_res[c])
    );
  end

  // Collect the lane results into one row item; rows beyond the matrix are
  // accepted and dropped without touching any state.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_item_nxt  = s1_item_r;
    if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
    if (lane_take) begin
      s1_valid_nxt      = 1'b1;
      s1_item_nxt.row   = in_row_index;
      s1_item_nxt.stamp = now;
      for (int c = 0; c < COLS; c++) begin
        s1_item_nxt.fire[c]  = lane_res[c].fire;
        s1_item_nxt.level[c] = lane_res[c].level;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RESET;
      max_ev_r   <= MAX_EV_RESET;
      s1_valid_r <= 1'b0;
    end else begin
      debounce_r <= debounce_nxt;
      max_ev_r   <= max_ev_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= s1_item_nxt;
  end

  kmds_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid_r),
    .s1_item    (s1_item_r),
    .max_events (max_ev_r),
    .s1_take    (s1_take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ev         (ev)
  );

  assign out_key_row       = ev.key_row;
  assign out_key_column    = ev.key_column;
  assign out_is_pressed    = ev.is_pressed;
  assign out_event_time_ms = OUT_TIME_W'(ev.time_ms);
  assign out_last_of_row   = ev.last;

  // Back-pressure at the input only ever comes from a full row stage.
  `KMDS_ASSERT_SAME(a_ready_only_when_full, !in_ready, s1_valid_r)
  // A buffered row item that the emitter does not take stays intact.
  `KMDS_ASSERT_NEXT(a_row_item_held, s1_valid_r && !s1_take, s1_valid_r && $stable(s1_item_r))
  // The emitter never takes a row item from an empty row stage.
  `KMDS_ASSERT_SAME(a_take_needs_item, s1_take, s1_valid_r)

endmodule
`default_nettype wire

@@ verif/tb.sv @@
`default_nettype none
module tb;
  import kmds_pkg::*;

  // Register indexes with no register behind them; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Cycles to let pass once the last expected event is out. A row with no
  // events still passes through the row stage, so a row taken after the one
  // that produced the last event may still be inside the block at that point.
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 500000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [ROW_W-1:0]      in_row_index = '0;
  logic [LVL_W-1:0]      in_column_levels = '1;
  logic [31:0]           in_now_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ROW_W-1:0]      out_key_row;
  logic [COL_W-1:0]      out_key_column;
  logic                  out_is_pressed;
  logic [OUT_TIME_W-1:0] out_event_time_ms;
  logic                  out_last_of_row;

  key_matrix_debounce_scanner_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_row_index      (in_row_index),
    .in_column_levels  (in_column_levels),
    .in_now_ms         (in_now_ms),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_key_row       (out_key_row),
    .out_key_column    (out_key_column),
    .out_is_pressed    (out_is_pressed),
    .out_event_time_ms (out_event_time_ms),
    .out_last_of_row   (out_last_of_row)
  );

  always #5 clk = ~clk;

  // Our own copy of the scanner state: per-key raw level, debounced level and
  // time of the last raw change, plus the per-scan event count and the two
  // registers as last written.
  logic [COLS-1:0]   key_raw    [ROWS] = '{default: '0};
  logic [COLS-1:0]   key_stable [ROWS] = '{default: '0};
  logic [TIME_W-1:0] key_stamp  [ROWS][COLS] = '{default: '{default: '0}};
  logic [CNT_W-1:0]  scan_count = '0;
  logic [DEB_W-1:0]  debounce_q = DEBOUNCE_RESET;
  logic [CNT_W-1:0]  event_cap = MAX_EV_RESET;

  event_t pending_events [$];
  int     mismatch_count = 0;
  int     cycle_count = 0;

  // Percent chance, per cycle, that the row source holds back or the event
  // sink refuses an event. Each random phase sets its own pair.
  int row_idle_pct = 0;
  int sink_stall_pct = 0;

  // Working copy of the column levels per row for the random traffic, so that
  // most rows differ from their previous sample by a bit or two, like bouncing
  // contacts, instead of being fresh noise every time.
  logic [LVL_W-1:0] row_levels [ROWS] = '{default: '1};

  // Runs one row sample through the key state and queues the events it must
  // produce, in column order, with the final one flagged. Every row index a
  // 3-bit field can carry is a real row here, so nothing is ignored.
  function automatic void debounce_row(input logic [ROW_W-1:0] row,
                                       input logic [LVL_W-1:0] levels,
                                       input logic [TIME_W-1:0] stamp);
    event_t            fired [COLS];
    int                n;
    logic              pressed;
    logic [TIME_W-1:0] elapsed;
    n = 0;
    if (row == '0) begin
      scan_count = '0;
    end
    for (int c = 0; c < COLS; c++) begin
      // Active-low pins: a 0 means the key is down.
      pressed = ~levels[c];
      if (pressed != key_raw[row][c]) begin
        key_raw[row][c] = pressed;
        key_stamp[row][c] = stamp;
      end
      // The subtraction wraps in 32 bits, so a stamp taken just before the
      // counter rolls over still ages correctly.
      elapsed = stamp - key_stamp[row][c];
      if (elapsed >= TIME_W'(debounce_q) && key_stable[row][c] != key_raw[row][c]) begin
        key_stable[row][c] = key_raw[row][c];
        // Past the cap the debounced level still follows, only the event is lost.
        if (scan_count < event_cap) begin
          fired[n].key_row = row;
          fired[n].key_column = COL_W'(c);
          fired[n].is_pressed = key_raw[row][c];
          fired[n].time_ms = stamp;
          fired[n].last = 1'b0;
          n++;
          scan_count = scan_count + 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      fired[i].last = (i == n - 1);
      pending_events.push_back(fired[i]);
    end
  endfunction

  // One process watches all three channels at each edge, so the key state,
  // the registers and the queue of expected events always move in the order
  // the handshakes happened, whatever order the stimulus tasks wake up in.
  always @(posedge clk) begin
    event_t got;
    event_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE_MS: debounce_q = cfg_data[DEB_W-1:0];
          REG_MAX_EVENTS:  event_cap = cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        debounce_row(in_row_index, in_column_levels, in_now_ms);
      end
      if (out_valid && out_ready) begin
        got.key_row = out_key_row;
        got.key_column = out_key_column;
        got.is_pressed = out_is_pressed;
        got.time_ms = out_event_time_ms;
        got.last = out_last_of_row;
        if (pending_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("unexpected event: row %0d col %0d pressed %0b t %h last %0b",
                     got.key_row, got.key_column, got.is_pressed, got.time_ms, got.last);
          end
        end else begin
          want = pending_events.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("event differs: expected row %0d col %0d pressed %0b t %h last %0b",
                       want.key_row, want.key_column, want.is_pressed, want.time_ms,
                       want.last);
              $display("                 actual row %0d col %0d pressed %0b t %h last %0b",
                       got.key_row, got.key_column, got.is_pressed, got.time_ms, got.last);
            end
          end
        end
      end
    end
  end

  // The sink decides afresh every cycle whether to take an event.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("key_matrix_debounce_scanner_unit: mismatch");
      $finish;
    end
  end

  // Presents one row sample and returns at the edge that takes it. Valid is
  // left high on return; the next call either replaces the payload or drops
  // valid for an idle cycle, in the same time step.
  task automatic send_row(input logic [ROW_W-1:0] row, input logic [LVL_W-1:0] levels,
                          input logic [31:0] stamp);
    while ($urandom_range(99) < row_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_row_index <= row;
    in_column_levels <= levels;
    in_now_ms <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stops the row source and waits until every expected event is out, then
  // gives rows that produce no events time to leave the block as well. The
  // first edge lets the checker queue the events of the row taken last.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes are only issued with the block quiet.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Reset debounce of 5 ms: a press becomes an event only after it held 5 ms,
  // a whole row pressed at once gives sixteen events, and the release of the
  // row gives sixteen more.
  task automatic test_debounce_basics();
    send_row(3'd0, 16'hFFFF, 32'd0);
    send_row(3'd0, 16'hFFFE, 32'd10);
    send_row(3'd0, 16'hFFFE, 32'd14);
    send_row(3'd0, 16'hFFFE, 32'd15);
    send_row(3'd7, 16'h0000, 32'd100);
    send_row(3'd7, 16'h0000, 32'd105);
    send_row(3'd7, 16'hFFFF, 32'd200);
    send_row(3'd7, 16'hFFFF, 32'd205);
  endtask

  // With a debounce time of zero a new level is taken in the same row sample.
  task automatic test_zero_debounce();
    wait_quiet();
    write_reg(REG_DEBOUNCE_MS, 16'h0000);
    send_row(3'd1, 16'h5555, 32'd400);
    send_row(3'd1, 16'hAAAA, 32'd401);
  endtask

  // Longest debounce, with the key's timer started just before the time
  // counter rolls over: one millisecond short is not enough, the next is.
  task automatic test_time_wrap();
    wait_quiet();
    write_reg(REG_DEBOUNCE_MS, 16'hFFFF);
    send_row(3'd4, 16'h7FFF, 32'hFFFF_FFF0);
    send_row(3'd4, 16'h7FFF, 32'h0000_FFEE);
    send_row(3'd4, 16'h7FFF, 32'h0000_FFEF);
  endtask

  // Event cap per scan: flips beyond the cap change the keys silently, row 0
  // opens a fresh budget, a cap of zero silences everything, and writes to
  // unused register indexes leave both registers alone.
  task automatic test_event_cap();
    wait_quiet();
    write_reg(REG_DEBOUNCE_MS, 16'h0000);
    write_reg(REG_MAX_EVENTS, 16'hFF03);
    send_row(3'd0, 16'h0F0F, 32'd1000);
    send_row(3'd5, 16'h0000, 32'd1001);
    send_row(3'd0, 16'hFFFF, 32'd1002);
    wait_quiet();
    write_reg(REG_MAX_EVENTS, 16'h0000);
    send_row(3'd0, 16'h0000, 32'd1003);
    wait_quiet();
    write_reg(REG_MAX_EVENTS, 16'hFFFF);
    send_row(3'd0, 16'hFFFF, 32'd1004);
    wait_quiet();
    write_reg(REG_SPARE_2, 16'h0000);
    write_reg(REG_SPARE_3, 16'hFFFF);
    send_row(3'd6, 16'hFFFE, 32'd1005);
  endtask

  // Random scans under one register setting and one idling pattern. Rows
  // mostly come in scan order with time creeping forward and levels changing
  // by a bit or two; now and then a row is out of order, the levels are fresh
  // noise, or time jumps far ahead.
  task automatic test_random_scan(input int idle_pct, input int stall_pct,
                                  input logic [CFG_DATA_W-1:0] debounce,
                                  input logic [CFG_DATA_W-1:0] cap,
                                  input int items, input int step_max);
    logic [ROW_W-1:0] row;
    logic [31:0]      now_ms;
    int               pick;
    wait_quiet();
    row_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    write_reg(REG_DEBOUNCE_MS, debounce);
    write_reg(REG_MAX_EVENTS, cap);
    row = '1;
    now_ms = $urandom();
    for (int i = 0; i < items; i++) begin
      row = ($urandom_range(9) == 0) ? ROW_W'($urandom_range(ROWS - 1)) : row + 1'b1;
      pick = $urandom_range(99);
      if (pick < 60) begin
        row_levels[row][COL_W'($urandom_range(COLS - 1))] ^= 1'b1;
      end else if (pick < 75) begin
        row_levels[row][COL_W'($urandom_range(COLS - 1))] ^= 1'b1;
        row_levels[row][COL_W'($urandom_range(COLS - 1))] ^= 1'b1;
      end else if (pick < 85) begin
        row_levels[row] = LVL_W'($urandom());
      end
      pick = $urandom_range(99);
      if (pick < 4) begin
        now_ms += $urandom_range(200000, 65536);
      end else if (pick < 6) begin
        now_ms += $urandom();
      end else begin
        now_ms += $urandom_range(step_max);
      end
      send_row(row, row_levels[row], now_ms);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_debounce_basics();
    test_zero_debounce();
    test_time_wrap();
    test_event_cap();
    test_random_scan(0, 0, 16'd3, 16'h0080, 100, 2);
    test_random_scan(60, 0, 16'd0, 16'd5, 90, 1);
    test_random_scan(0, 60, 16'd8, 16'h00FF, 90, 3);
    test_random_scan(31, 31, 16'hFFFF, 16'h0080, 50, 4);
    test_random_scan(31, 31, 16'd2, 16'd20, 80, 2);
    wait_quiet();
    mismatch_count += pending_events.size();
    if (mismatch_count == 0) begin
      $display("key_matrix_debounce_scanner_unit: match");
    end else begin
      $display("key_matrix_debounce_scanner_unit: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
